// ===== design/h2pt_pkg.sv =====
// h2pt_pkg: shared types, codes and constants of the homogeneous 2-d point transform unit
// used by the controller, the datapath, the top level and the checker; no dependencies

package h2pt_pkg;

   localparam int CoefCount = 9;

   localparam logic [1:0] CMD_IDENTITY  = 2'd0;
   localparam logic [1:0] CMD_COMPOSE   = 2'd1;
   localparam logic [1:0] CMD_TRANSFORM = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_WZERO = 2'd1;
   localparam logic [1:0] STATUS_SAT   = 2'd2;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   // second multiplier operand select: operand coefficients 0..8, then these
   localparam logic [3:0] BSEL_PX  = 4'd9;
   localparam logic [3:0] BSEL_PY  = 4'd10;
   localparam logic [3:0] BSEL_ONE = 4'd11;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] coef_00;
      logic signed [31:0] coef_01;
      logic signed [31:0] coef_02;
      logic signed [31:0] coef_10;
      logic signed [31:0] coef_11;
      logic signed [31:0] coef_12;
      logic signed [31:0] coef_20;
      logic signed [31:0] coef_21;
      logic signed [31:0] coef_22;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_COMMIT,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       ident;
      logic       acc_clr;
      logic       acc_add;
      logic       fin_compose;
      logic       fin_xform;
      logic [3:0] dst;
      logic [3:0] a_idx;
      logic [3:0] b_sel;
      logic       commit;
      logic       div_start;
      logic       div_step;
      logic       rsp_load;
   } ctrl_type;

endpackage

// ===== design/h2pt_ctrl.sv =====
// h2pt_ctrl: sequencer of the point transform unit; drives the datapath by command struct
// depends on h2pt_pkg

module h2pt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_command,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output h2pt_pkg::ctrl_type ctrl
);

   h2pt_pkg::state_type state_ff, state_in;
   logic [2:0] ph_ff, ph_in;
   logic [1:0] col_ff, col_in;
   logic [1:0] row_ff, row_in;
   logic [5:0] dcnt_ff, dcnt_in;
   logic       xform_ff, xform_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic accept;
   logic mac_done;
   logic out_free;

   assign accept   = req_valid && !req_stall;
   assign mac_done = (ph_ff == 3'd4) && (col_ff == 2'd2) && (xform_ff || row_ff == 2'd2);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         h2pt_pkg::ST_IDLE: begin
            if (accept && (req_command == h2pt_pkg::CMD_COMPOSE ||
                           req_command == h2pt_pkg::CMD_TRANSFORM)) begin
               state_in = h2pt_pkg::ST_MAC;
            end
         end
         h2pt_pkg::ST_MAC: begin
            if (mac_done) begin
               state_in = xform_ff ? h2pt_pkg::ST_DIV : h2pt_pkg::ST_COMMIT;
            end
         end
         h2pt_pkg::ST_COMMIT: begin
            state_in = h2pt_pkg::ST_IDLE;
         end
         h2pt_pkg::ST_DIV: begin
            if (dcnt_ff == 6'd32) begin
               state_in = h2pt_pkg::ST_OUT;
            end
         end
         h2pt_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = h2pt_pkg::ST_IDLE;
            end
         end
         default: state_in = h2pt_pkg::ST_IDLE;
      endcase
   end

   // counters
   always_comb begin
      ph_in    = ph_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      dcnt_in  = dcnt_ff;
      xform_in = xform_ff;
      case (state_ff)
         h2pt_pkg::ST_IDLE: begin
            ph_in   = 3'd0;
            col_in  = 2'd0;
            row_in  = 2'd0;
            dcnt_in = 6'd0;
            if (accept) begin
               xform_in = (req_command == h2pt_pkg::CMD_TRANSFORM);
            end
         end
         h2pt_pkg::ST_MAC: begin
            if (ph_ff == 3'd4) begin
               ph_in = 3'd0;
               if (col_ff == 2'd2) begin
                  col_in = 2'd0;
                  row_in = row_ff + 2'd1;
               end else begin
                  col_in = col_ff + 2'd1;
               end
            end else begin
               ph_in = ph_ff + 3'd1;
            end
         end
         h2pt_pkg::ST_DIV: begin
            dcnt_in = dcnt_ff + 6'd1;
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      ctrl      = '0;
      req_stall = (state_ff != h2pt_pkg::ST_IDLE);
      case (state_ff)
         h2pt_pkg::ST_IDLE: begin
            if (accept) begin
               ctrl.capture = 1'b1;
               ctrl.ident   = (req_command == h2pt_pkg::CMD_IDENTITY);
            end
         end
         h2pt_pkg::ST_MAC: begin
            ctrl.acc_clr = (ph_ff == 3'd0);
            ctrl.acc_add = (ph_ff != 3'd0) && (ph_ff != 3'd4);
            if (xform_ff) begin
               ctrl.a_idx = 4'({1'b0, ph_ff} * 4'd3) + 4'(col_ff);
               case (ph_ff)
                  3'd0:    ctrl.b_sel = h2pt_pkg::BSEL_PX;
                  3'd1:    ctrl.b_sel = h2pt_pkg::BSEL_PY;
                  default: ctrl.b_sel = h2pt_pkg::BSEL_ONE;
               endcase
               ctrl.dst       = 4'(col_ff);
               ctrl.fin_xform = (ph_ff == 3'd4);
            end else begin
               ctrl.a_idx = 4'({2'b0, row_ff} * 4'd3) + 4'(ph_ff);
               ctrl.b_sel = 4'({1'b0, ph_ff} * 4'd3) + 4'(col_ff);
               ctrl.dst   = 4'({2'b0, row_ff} * 4'd3) + 4'(col_ff);
               ctrl.fin_compose = (ph_ff == 3'd4);
            end
         end
         h2pt_pkg::ST_COMMIT: begin
            ctrl.commit = 1'b1;
         end
         h2pt_pkg::ST_DIV: begin
            ctrl.div_start = (dcnt_ff == 6'd0);
            ctrl.div_step  = (dcnt_ff != 6'd0);
         end
         h2pt_pkg::ST_OUT: begin
            ctrl.rsp_load = out_free;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = ctrl.rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= h2pt_pkg::ST_IDLE;
         ph_ff        <= 3'd0;
         col_ff       <= 2'd0;
         row_ff       <= 2'd0;
         dcnt_ff      <= 6'd0;
         xform_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         dcnt_ff      <= dcnt_in;
         xform_ff     <= xform_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/h2pt_datapath.sv =====
// h2pt_datapath: matrix store, shared multiplier and accumulator, two radix-2 dividers
// depends on h2pt_pkg; sequenced by h2pt_ctrl

module h2pt_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  h2pt_pkg::ctrl_type ctrl,
   input  h2pt_pkg::req_type  req_data,
   output h2pt_pkg::rsp_type  rsp_data
);

   localparam int AW = 66;
   localparam int VW = AW - FRAC_BITS;
   localparam logic signed [31:0] ONE_Q  = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [AW-1:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

   logic signed [31:0] mat_ff [h2pt_pkg::CoefCount];
   logic signed [31:0] nm_ff  [h2pt_pkg::CoefCount];
   logic signed [31:0] op_ff  [h2pt_pkg::CoefCount];
   logic signed [31:0] px_ff, py_ff;

   logic signed [31:0]   a_op, b_op;
   logic signed [63:0]   prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff;
   logic signed [AW-1:0] rnd_full;
   logic signed [31:0]   rnd_sat;
   logic signed [VW-1:0] v_ff [3];

   // divider lanes: 0 is x, 1 is y
   logic [VW-1:0] mag_v [3];
   logic [AW-1:0] dvd   [2];
   logic [AW:0]   divw_ff;
   logic [AW:0]   rem_ff [2];
   logic [AW:0]   shr    [2];
   logic [31:0]   dq_ff  [2];
   logic [31:0]   q_ff   [2];
   logic          ovf_ff [2];
   logic          neg_ff [2];
   logic          wz_ff;

   logic signed [31:0] res [2];
   logic               lsat [2];
   h2pt_pkg::rsp_type  rsp_ff, rsp_in;

   assign a_op = mat_ff[ctrl.a_idx];

   always_comb begin
      case (ctrl.b_sel)
         h2pt_pkg::BSEL_PX:  b_op = px_ff;
         h2pt_pkg::BSEL_PY:  b_op = py_ff;
         h2pt_pkg::BSEL_ONE: b_op = ONE_Q;
         default: begin
            if (ctrl.b_sel < 4'(h2pt_pkg::CoefCount)) begin
               b_op = op_ff[ctrl.b_sel];
            end else begin
               b_op = '0;
            end
         end
      endcase
   end

   assign prod_in  = a_op * b_op;
   // the accumulator starts at one half, so the shift rounds half up
   assign rnd_full = acc_ff >>> FRAC_BITS;

   always_comb begin
      if (rnd_full > AW'(h2pt_pkg::Q_MAX)) begin
         rnd_sat = h2pt_pkg::Q_MAX;
      end else if (rnd_full < AW'(h2pt_pkg::Q_MIN)) begin
         rnd_sat = h2pt_pkg::Q_MIN;
      end else begin
         rnd_sat = rnd_full[31:0];
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mag_v[c] = v_ff[c][VW-1] ? VW'(-v_ff[c]) : VW'(v_ff[c]);
      end
      for (int l = 0; l < 2; l++) begin
         dvd[l] = {mag_v[l], {FRAC_BITS{1'b0}}};
         shr[l] = {rem_ff[l][AW-1:0], dq_ff[l][31]};
      end
   end

   // final quotient, saturated where it leaves the 32-bit range
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (neg_ff[l]) begin
            lsat[l] = ovf_ff[l] || (q_ff[l][31] && (q_ff[l][30:0] != 31'd0));
            res[l]  = lsat[l] ? h2pt_pkg::Q_MIN : -$signed(q_ff[l]);
         end else begin
            lsat[l] = ovf_ff[l] || q_ff[l][31];
            res[l]  = lsat[l] ? h2pt_pkg::Q_MAX : $signed(q_ff[l]);
         end
      end
      if (wz_ff) begin
         rsp_in.out_x  = '0;
         rsp_in.out_y  = '0;
         rsp_in.status = h2pt_pkg::STATUS_WZERO;
      end else begin
         rsp_in.out_x  = res[0];
         rsp_in.out_y  = res[1];
         rsp_in.status = (lsat[0] || lsat[1]) ? h2pt_pkg::STATUS_SAT : h2pt_pkg::STATUS_OK;
      end
   end

   // matrix, set to identity on reset or an identity command, loaded from the new matrix on commit
   always_ff @(posedge clock) begin
      if (reset || ctrl.ident) begin
         for (int i = 0; i < h2pt_pkg::CoefCount; i++) begin
            mat_ff[i] <= (i % 4 == 0) ? ONE_Q : 32'sd0;
         end
      end else if (ctrl.commit) begin
         for (int i = 0; i < h2pt_pkg::CoefCount; i++) begin
            mat_ff[i] <= nm_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         op_ff[0] <= req_data.coef_00;
         op_ff[1] <= req_data.coef_01;
         op_ff[2] <= req_data.coef_02;
         op_ff[3] <= req_data.coef_10;
         op_ff[4] <= req_data.coef_11;
         op_ff[5] <= req_data.coef_12;
         op_ff[6] <= req_data.coef_20;
         op_ff[7] <= req_data.coef_21;
         op_ff[8] <= req_data.coef_22;
         px_ff    <= req_data.point_x;
         py_ff    <= req_data.point_y;
      end
      prod_ff <= prod_in;
      if (ctrl.acc_clr) begin
         acc_ff <= HALF;
      end else if (ctrl.acc_add) begin
         acc_ff <= acc_ff + {{(AW-64){prod_ff[63]}}, prod_ff};
      end
      if (ctrl.fin_compose) begin
         nm_ff[ctrl.dst] <= rnd_sat;
      end
      if (ctrl.fin_xform) begin
         v_ff[ctrl.dst[1:0]] <= rnd_full[VW-1:0];
      end
      if (ctrl.div_start) begin
         divw_ff <= (AW+1)'(mag_v[2]);
         wz_ff   <= (v_ff[2] == '0);
         for (int l = 0; l < 2; l++) begin
            rem_ff[l] <= (AW+1)'(dvd[l][AW-1:32]);
            dq_ff[l]  <= dvd[l][31:0];
            q_ff[l]   <= '0;
            ovf_ff[l] <= (AW+1)'(dvd[l][AW-1:32]) >= (AW+1)'(mag_v[2]);
            neg_ff[l] <= v_ff[l][VW-1] ^ v_ff[2][VW-1];
         end
      end else if (ctrl.div_step) begin
         for (int l = 0; l < 2; l++) begin
            dq_ff[l] <= {dq_ff[l][30:0], 1'b0};
            if (shr[l] >= divw_ff) begin
               rem_ff[l] <= shr[l] - divw_ff;
               q_ff[l]   <= {q_ff[l][30:0], 1'b1};
            end else begin
               rem_ff[l] <= shr[l];
               q_ff[l]   <= {q_ff[l][30:0], 1'b0};
            end
         end
      end
      if (ctrl.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== design/homogeneous_2d_point_transform_unit.sv =====
// Homogeneous 2-D point transform unit. Holds a 3x3 Q(31-FRAC_BITS).FRAC_BITS matrix,
// identity after reset. A command 0 transaction sets the matrix back to identity; a compose
// (command 1) forms each matrix entry on the single shared 32x32 multiplier and then
// commits the new matrix; a transform (command 2) uses the multiplier and then the pair of
// radix-2 dividers that produce x/w and y/w one quotient bit per cycle. One
// transaction is worked on at a time; the input stalls for its duration, and the next
// transaction can be taken while a result still waits in the output register.
//
// top level: joins h2pt_ctrl and h2pt_datapath; depends on h2pt_pkg

module homogeneous_2d_point_transform_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  h2pt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output h2pt_pkg::rsp_type rsp_data
);

   h2pt_pkg::ctrl_type ctrl;

   h2pt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_data.command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .ctrl        (ctrl)
   );

   h2pt_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ===== design/h2pt_checker.sv =====
// h2pt_checker: port-level assertions for the point transform unit, bound to the top level
// depends on h2pt_pkg

module h2pt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input h2pt_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input h2pt_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response transaction changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_wzero_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == h2pt_pkg::STATUS_WZERO |->
         rsp_data.out_x == 32'sd0 && rsp_data.out_y == 32'sd0)
      else $error("zero w with non-zero coordinates");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == h2pt_pkg::STATUS_SAT |->
         rsp_data.out_x == h2pt_pkg::Q_MAX || rsp_data.out_x == h2pt_pkg::Q_MIN ||
         rsp_data.out_y == h2pt_pkg::Q_MAX || rsp_data.out_y == h2pt_pkg::Q_MIN)
      else $error("saturation reported with no coordinate at a limit");

   // a compose or transform keeps the input stalled while it is worked on
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.command == h2pt_pkg::CMD_COMPOSE ||
         req_data.command == h2pt_pkg::CMD_TRANSFORM) |=> req_stall)
      else $error("input open while a transaction is in progress");

endmodule

bind homogeneous_2d_point_transform_unit h2pt_checker u_h2pt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
